>>> sv/vector_allpass_delay_filter_assert.svh
// Assertion helpers for the allpass filter block.
`ifndef VECTOR_ALLPASS_DELAY_FILTER_ASSERT_SVH
`define VECTOR_ALLPASS_DELAY_FILTER_ASSERT_SVH

// same-cycle implication
`define VAPD_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vapd: same-cycle check failed");

// next-cycle implication
`define VAPD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vapd: next-cycle check failed");

`endif

>>> sv/vapd_pkg.sv
package vapd_pkg;

    localparam int LANES     = 8;
    localparam int LAST_LANE = LANES - 1;
    localparam int LANE_W    = $clog2(LANES);

    localparam int SAMPLE_W  = 16;
    localparam int ACC_W     = 34;
    localparam int FRAC_W    = 14;
    localparam int RING_W    = 13;
    localparam int DLY_W     = 12;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [1:0] REG_AM    = 2'd0;
    localparam logic [1:0] REG_B0    = 2'd1;
    localparam logic [1:0] REG_RING  = 2'd2;
    localparam logic [1:0] REG_DELAY = 2'd3;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [ACC_W-1:0]    t_acc;

    localparam t_sample AM_RST    = 16'sd0;
    localparam t_sample B0_RST    = 16'sd16384;
    localparam logic [RING_W-1:0] RING_RST  = 13'd4096;
    localparam logic [DLY_W-1:0]  DELAY_RST = 12'd8;
    localparam logic [RING_W-1:0] RING_MIN  = 13'd8;

    localparam t_acc ACC_HALF = 34'sd8192;
    localparam t_acc ACC_MAX  = 34'sd32767;
    localparam t_acc ACC_MIN  = -34'sd32768;

    typedef struct packed {
        t_sample sample_0;
        t_sample sample_1;
        t_sample sample_2;
        t_sample sample_3;
        t_sample sample_4;
        t_sample sample_5;
        t_sample sample_6;
        t_sample sample_7;
    } t_in_item;

    typedef struct packed {
        t_sample filtered_0;
        t_sample filtered_1;
        t_sample filtered_2;
        t_sample filtered_3;
        t_sample filtered_4;
        t_sample filtered_5;
        t_sample filtered_6;
        t_sample filtered_7;
    } t_out_item;

    typedef struct packed {
        logic v_en;
        logic y_en;
    } t_lane_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_stat;

    // divide by 2^14, round half up, clamp to 16 bits
    function automatic t_sample round_sat(input t_acc acc);
        t_acc a;
        t_acc q;
        a = acc + ACC_HALF;
        q = a >>> FRAC_W;
        if (q > ACC_MAX) begin
            q = ACC_MAX;
        end else if (q < ACC_MIN) begin
            q = ACC_MIN;
        end
        return t_sample'(q);
    endfunction

endpackage

>>> sv/vapd_ram.sv
module vapd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/vapd_lane.sv
module vapd_lane (
    input  logic               i_clk,
    input  vapd_pkg::t_lane_ctl i_ctl,
    input  vapd_pkg::t_sample  i_x,
    input  vapd_pkg::t_sample  i_d,
    input  vapd_pkg::t_sample  i_am,
    input  vapd_pkg::t_sample  i_b0,
    output vapd_pkg::t_sample  o_v,
    output vapd_pkg::t_sample  o_y
);

    import vapd_pkg::*;

    logic signed [2*SAMPLE_W-1:0] prod_v;
    logic signed [2*SAMPLE_W-1:0] prod_y;
    t_acc    acc_v;
    t_acc    acc_y;
    t_sample r_v;
    t_sample r_y;

    // full-width signed products
    assign prod_v = i_am * i_d;
    assign prod_y = i_b0 * r_v;

    // v = x - am*d
    assign acc_v = (t_acc'(i_x) <<< FRAC_W) - t_acc'(prod_v);
    // y = b0*v + d
    assign acc_y = t_acc'(prod_y) + (t_acc'(i_d) <<< FRAC_W);

    always_ff @(posedge i_clk) begin
        if (i_ctl.v_en) begin
            r_v <= round_sat(acc_v);
        end
        if (i_ctl.y_en) begin
            r_y <= round_sat(acc_y);
        end
    end

    assign o_v = r_v;
    assign o_y = r_y;

endmodule

>>> sv/vapd_modu.sv
module vapd_modu #(
    parameter int POS_W = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [vapd_pkg::DLY_W-1:0]  i_dividend,
    input  logic [POS_W:0]              i_divisor,
    output vapd_pkg::t_mod_stat         o_stat,
    output logic [POS_W-1:0]            o_rem
);

    import vapd_pkg::*;

    localparam int CNT_W = $clog2(DLY_W + 1);
    localparam int IDX_W = $clog2(DLY_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [POS_W-1:0] r_rem;
    logic [IDX_W-1:0] bit_idx;
    logic [POS_W:0]   shifted;
    logic [POS_W-1:0] n_rem;

    // restoring remainder, one dividend bit per cycle
    assign bit_idx = IDX_W'(r_cnt - CNT_W'(1));
    assign shifted = {r_rem, i_dividend[bit_idx]};
    assign n_rem   = (shifted >= i_divisor) ? POS_W'(shifted - i_divisor) : shifted[POS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DLY_W);
            r_rem  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DLY_W);
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule

>>> sv/vector_allpass_delay_filter.sv
// Vector allpass filter: eight Q1.15 samples in, eight filtered samples out.
// Input channel i_in_valid / o_in_stall / i_in_data, output channel
// o_out_valid / i_out_stall / o_out_data; a transaction moves when valid is
// high and stall is low. Coefficients and ring geometry sit behind an APB
// port; the user is to have them written only while no transaction is in flight,
// which the block leaves unchecked. One item at a time: the delay store has a
// single read and a single write port, so the eight reads are done one
// after another, as are the eight writes. A new item is taken only after
// the block returns to idle. The next item may be taken while a result
// still waits. After reset the store is cleared, one entry a cycle, over
// all STORE_DEPTH entries; o_in_stall stays high meanwhile. A write to
// ring_length or delay_length recomputes the write position, stalling input.
// A stalled result holds in the output register; the block finishes the
// next item and then waits with it until the output register frees up.
`include "vector_allpass_delay_filter_assert.svh"

module vector_allpass_delay_filter #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  vapd_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output vapd_pkg::t_out_item          o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vapd_pkg::ADDR_W-1:0]  paddr,
    input  logic [vapd_pkg::DATA_W-1:0]  pwdata,
    output logic [vapd_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    import vapd_pkg::*;

    localparam int AW   = $clog2(STORE_DEPTH);
    localparam int CW   = (RING_W > AW + 1) ? RING_W : AW + 1;
    localparam logic [CW-1:0] DEPTH_C  = CW'(STORE_DEPTH);
    localparam logic [AW-1:0] LAST_CLR = AW'(STORE_DEPTH - 1);

    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_CAP   = 8'b0000_1000,
        S_VCALC = 8'b0001_0000,
        S_YCALC = 8'b0010_0000,
        S_WRITE = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    t_sample           r_am;
    t_sample           r_b0;
    logic [RING_W-1:0] r_ring_len;
    logic [DLY_W-1:0]  r_dly_len;
    logic [AW:0]       ring_use;
    logic [CW-1:0]     ring_ext;

    logic [LANE_W-1:0] r_cnt;
    logic [AW-1:0]     r_clr;
    logic [AW-1:0]     r_rd_pos;
    logic [AW-1:0]     r_wr_pos;
    logic              r_cap_en;
    logic [LANE_W-1:0] r_cap_idx;
    t_sample           r_x [LANES];
    t_sample           r_d [LANES];
    t_sample           lane_v [LANES];
    t_sample           lane_y [LANES];
    logic              r_out_valid;
    t_out_item         r_out;

    logic              cfg_wr;
    logic              geom_wr;
    logic              in_acc;
    logic              out_free;
    t_lane_ctl         lane_ctl;
    t_mod_stat         mod_stat;
    logic [AW-1:0]     mod_rem;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    t_sample           ram_wr_data;
    t_sample           ram_rd_data;

    function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p, input logic [AW:0] ring);
        logic [AW:0] p1;
        p1 = {1'b0, p} + (AW + 1)'(1);
        return (p1 >= ring) ? '0 : p1[AW-1:0];
    endfunction

    // configuration
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign geom_wr = cfg_wr && ((paddr[3:2] == REG_RING) || (paddr[3:2] == REG_DELAY));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_am       <= AM_RST;
            r_b0       <= B0_RST;
            r_ring_len <= RING_RST;
            r_dly_len  <= DELAY_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_AM:    r_am       <= t_sample'(pwdata[SAMPLE_W-1:0]);
                REG_B0:    r_b0       <= t_sample'(pwdata[SAMPLE_W-1:0]);
                REG_RING:  r_ring_len <= pwdata[RING_W-1:0];
                REG_DELAY: r_dly_len  <= pwdata[DLY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_AM:    prdata = {{(DATA_W - SAMPLE_W){1'b0}}, r_am};
            REG_B0:    prdata = {{(DATA_W - SAMPLE_W){1'b0}}, r_b0};
            REG_RING:  prdata = {{(DATA_W - RING_W){1'b0}}, r_ring_len};
            REG_DELAY: prdata = {{(DATA_W - DLY_W){1'b0}}, r_dly_len};
            default:   prdata = '0;
        endcase
    end

    // ring length clamped to [8, STORE_DEPTH]
    assign ring_ext = CW'(r_ring_len);
    always_comb begin
        if (ring_ext < CW'(RING_MIN)) begin
            ring_use = (AW + 1)'(RING_MIN);
        end else if (ring_ext > DEPTH_C) begin
            ring_use = (AW + 1)'(DEPTH_C);
        end else begin
            ring_use = (AW + 1)'(ring_ext);
        end
    end

    vapd_modu #(
        .POS_W (AW)
    ) u_modu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (geom_wr),
        .i_dividend (r_dly_len),
        .i_divisor  (ring_use),
        .o_stat     (mod_stat),
        .o_rem      (mod_rem)
    );

    // handshake
    assign o_in_stall = (r_state != S_IDLE) || mod_stat.busy;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT:  if (r_clr == LAST_CLR) n_state = S_IDLE;
            S_IDLE:  if (in_acc) n_state = S_READ;
            S_READ:  if (r_cnt == LANE_W'(LAST_LANE)) n_state = S_CAP;
            S_CAP:   n_state = S_VCALC;
            S_VCALC: n_state = S_YCALC;
            S_YCALC: n_state = S_WRITE;
            S_WRITE: if (r_cnt == LANE_W'(LAST_LANE)) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_clr       <= '0;
            r_rd_pos    <= '0;
            r_wr_pos    <= '0;
            r_cap_en    <= 1'b0;
            r_cap_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cap_en <= (r_state == S_READ);

            if (r_state == S_INIT) begin
                r_clr <= r_clr + AW'(1);
            end

            if ((r_state == S_READ) || (r_state == S_WRITE)) begin
                r_cnt <= r_cnt + LANE_W'(1);
            end else begin
                r_cnt <= '0;
            end

            if (r_state == S_READ) begin
                r_cap_idx <= r_cnt;
            end

            if (geom_wr) begin
                r_rd_pos <= '0;
            end else if (r_state == S_READ) begin
                r_rd_pos <= next_pos(r_rd_pos, ring_use);
            end

            if (mod_stat.done) begin
                r_wr_pos <= mod_rem;
            end else if (r_state == S_WRITE) begin
                r_wr_pos <= next_pos(r_wr_pos, ring_use);
            end

            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sample and delayed-value holding registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x[0] <= i_in_data.sample_0;
            r_x[1] <= i_in_data.sample_1;
            r_x[2] <= i_in_data.sample_2;
            r_x[3] <= i_in_data.sample_3;
            r_x[4] <= i_in_data.sample_4;
            r_x[5] <= i_in_data.sample_5;
            r_x[6] <= i_in_data.sample_6;
            r_x[7] <= i_in_data.sample_7;
        end
        if (r_cap_en) begin
            r_d[r_cap_idx] <= ram_rd_data;
        end
    end

    // delay store
    assign ram_wr_en   = (r_state == S_INIT) || (r_state == S_WRITE);
    assign ram_wr_addr = (r_state == S_INIT) ? r_clr : r_wr_pos;
    assign ram_wr_data = (r_state == S_INIT) ? t_sample'(0) : lane_v[r_cnt];

    vapd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (r_rd_pos),
        .o_rd_data (ram_rd_data)
    );

    // lanes
    assign lane_ctl.v_en = (r_state == S_VCALC);
    assign lane_ctl.y_en = (r_state == S_YCALC);

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        vapd_lane u_lane (
            .i_clk (i_clk),
            .i_ctl (lane_ctl),
            .i_x   (r_x[g]),
            .i_d   (r_d[g]),
            .i_am  (r_am),
            .i_b0  (r_b0),
            .o_v   (lane_v[g]),
            .o_y   (lane_y[g])
        );
    end

    // merge lane results into the output register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out.filtered_0 <= lane_y[0];
            r_out.filtered_1 <= lane_y[1];
            r_out.filtered_2 <= lane_y[2];
            r_out.filtered_3 <= lane_y[3];
            r_out.filtered_4 <= lane_y[4];
            r_out.filtered_5 <= lane_y[5];
            r_out.filtered_6 <= lane_y[6];
            r_out.filtered_7 <= lane_y[7];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `VAPD_ASSERT_IMPL(a_init_stalls, i_clk, i_rst_n, r_state == S_INIT, o_in_stall)
    `VAPD_ASSERT_NEXT(a_acc_reads, i_clk, i_rst_n, in_acc, r_state == S_READ)
    `VAPD_ASSERT_NEXT(a_geom_reseat, i_clk, i_rst_n, geom_wr, r_rd_pos == '0)
    `VAPD_ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, (r_state == S_DONE) && out_free, o_out_valid)

endmodule

>>> dv/vector_allpass_delay_filter_tb.sv
module vector_allpass_delay_filter_tb;
    import vapd_pkg::*;

    localparam int STORE_DEPTH    = 4096;
    localparam int DRAIN_CYCLES   = 32;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 106;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    t_in_item            in_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_out_item           out_data;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [DATA_W-1:0]   pwdata    = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // transaction flags seen at the last rising edge
    logic                in_fire   = 1'b0;
    logic                out_fire  = 1'b0;

    t_in_item            sample_queue[$];
    t_out_item           filtered_q[$];
    bit                  in_quiet  = 1'b1;
    bit                  out_quiet = 1'b1;
    int                  in_wait   = 0;
    int                  out_wait  = 0;
    int                  fail_count   = 0;
    int                  result_count = 0;
    int                  stuck_cycles = 0;

    // filter state mirror
    t_sample             am_coef   = AM_RST;
    t_sample             b0_gain   = B0_RST;
    logic [RING_W-1:0]   ring_reg  = RING_RST;
    logic [DLY_W-1:0]    delay_reg = DELAY_RST;
    t_sample             delay_line [STORE_DEPTH];
    int                  rd_pos;
    int                  wr_pos;

    vector_allpass_delay_filter #(
        .STORE_DEPTH(STORE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic int ring_span();
        int r;
        r = int'(ring_reg);
        if (r < int'(RING_MIN)) begin
            r = int'(RING_MIN);
        end else if (r > STORE_DEPTH) begin
            r = STORE_DEPTH;
        end
        return r;
    endfunction

    function automatic void reseat_cursors();
        rd_pos = 0;
        wr_pos = int'(delay_reg) % ring_span();
    endfunction

    function automatic void apply_register(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        case (idx)
            REG_AM: begin
                am_coef = t_sample'(value[SAMPLE_W-1:0]);
            end
            REG_B0: begin
                b0_gain = t_sample'(value[SAMPLE_W-1:0]);
            end
            REG_RING: begin
                ring_reg = value[RING_W-1:0];
                reseat_cursors();
            end
            REG_DELAY: begin
                delay_reg = value[DLY_W-1:0];
                reseat_cursors();
            end
            default: begin
            end
        endcase
    endfunction

    // Q2.14 product back to Q1.15: round half up, clamp
    function automatic t_sample q14_to_sample(input longint acc);
        longint q;
        q = (acc + 64'sd8192) >>> FRAC_W;
        if (q > 32767) begin
            q = 32767;
        end else if (q < -32768) begin
            q = -32768;
        end
        return t_sample'(q);
    endfunction

    // all lane reads happen before any lane write
    function automatic t_out_item allpass_item(input t_in_item item);
        t_sample   taps [LANES];
        t_sample   v;
        longint    x;
        longint    d;
        int        ring;
        t_out_item res;
        ring = ring_span();
        for (int i = 0; i < LANES; i++) begin
            taps[i] = delay_line[rd_pos];
            rd_pos  = (rd_pos + 1 >= ring) ? 0 : rd_pos + 1;
        end
        for (int i = 0; i < LANES; i++) begin
            x = longint'(t_sample'(item[(LAST_LANE-i)*SAMPLE_W +: SAMPLE_W]));
            d = longint'(taps[i]);
            v = q14_to_sample(x * 16384 - longint'(am_coef) * d);
            res[(LAST_LANE-i)*SAMPLE_W +: SAMPLE_W] =
                q14_to_sample(longint'(b0_gain) * longint'(v) + d * 16384);
            delay_line[wr_pos] = v;
            wr_pos = (wr_pos + 1 >= ring) ? 0 : wr_pos + 1;
        end
        return res;
    endfunction

    function automatic int draw_wait(input bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 8));
    endfunction

    function automatic t_sample pick_extreme();
        case ($urandom_range(0, 4))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return 16'sh0001;
        endcase
    endfunction

    function automatic t_in_item random_item();
        t_in_item item;
        int       mode;
        mode = int'($urandom_range(0, 19));
        for (int i = 0; i < LANES; i++) begin
            if (mode < 12) begin
                item[i*SAMPLE_W +: SAMPLE_W] = t_sample'($urandom_range(0, 65535));
            end else if (mode < 17) begin
                item[i*SAMPLE_W +: SAMPLE_W] = t_sample'(int'($urandom_range(0, 4000)) - 2000);
            end else begin
                item[i*SAMPLE_W +: SAMPLE_W] = pick_extreme();
            end
        end
        return item;
    endfunction

    function automatic t_sample random_coef();
        case ($urandom_range(0, 2))
            0: return t_sample'($urandom_range(0, 65535));
            1: return t_sample'(int'($urandom_range(0, 24000)) - 12000);
            default: begin
                case ($urandom_range(0, 4))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return 16'sh0000;
                    3: return 16'sh4000;
                    default: return 16'shc000;
                endcase
            end
        endcase
    endfunction

    task automatic report_error(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    task automatic wait_idle();
        while (in_valid || sample_queue.size() != 0 || filtered_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (in_stall !== 1'b0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_register(idx, value);
    endtask

    task automatic set_filter(input t_sample am, input t_sample b0,
                              input int ring, input int dly);
        apb_write(REG_AM, DATA_W'(am));
        apb_write(REG_B0, DATA_W'(b0));
        apb_write(REG_RING, DATA_W'(ring));
        apb_write(REG_DELAY, DATA_W'(dly));
    endtask

    task automatic push_extremes();
        sample_queue.push_back(t_in_item'({8{16'h7fff}}));
        sample_queue.push_back(t_in_item'({8{16'h8000}}));
        sample_queue.push_back(t_in_item'({4{16'h7fff, 16'h8000}}));
        sample_queue.push_back(t_in_item'({16'h0001, 16'hffff, 16'h0002, 16'hfffe,
                                           16'h2000, 16'he000, 16'h0000, 16'h4000}));
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || in_fire)) begin
            if (in_wait > 0) begin
                in_wait--;
                in_valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
                in_data  <= sample_queue.pop_front();
                in_valid <= 1'b1;
                in_wait  = draw_wait(in_quiet);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result stall driver
    always @(negedge i_clk) begin
        if (out_fire) begin
            out_wait = draw_wait(out_quiet);
        end
        if (out_wait > 0) begin
            out_wait--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // monitor, checker and watchdog
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        bit        took_in;
        bit        took_out;
        took_in  = i_rst_n && in_valid && !in_stall;
        took_out = i_rst_n && (out_valid === 1'b1) && !out_stall;
        in_fire  <= took_in;
        out_fire <= took_out;
        if (took_in) begin
            filtered_q.push_back(allpass_item(in_data));
        end
        if (took_out) begin
            if (filtered_q.size() == 0) begin
                report_error($sformatf("result %0d with no transaction pending", result_count));
            end else begin
                want = filtered_q.pop_front();
                for (int i = 0; i < LANES; i++) begin
                    if (out_data[(LAST_LANE-i)*SAMPLE_W +: SAMPLE_W] !==
                        want[(LAST_LANE-i)*SAMPLE_W +: SAMPLE_W]) begin
                        report_error($sformatf("result %0d filtered_%0d got %0d want %0d",
                            result_count, i,
                            t_sample'(out_data[(LAST_LANE-i)*SAMPLE_W +: SAMPLE_W]),
                            t_sample'(want[(LAST_LANE-i)*SAMPLE_W +: SAMPLE_W])));
                    end
                end
            end
            result_count++;
        end
        if (took_in || took_out) begin
            stuck_cycles = 0;
        end else if (i_rst_n) begin
            stuck_cycles++;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        int ring;
        int span;
        int dly;
        int r;
        foreach (delay_line[i]) begin
            delay_line[i] = '0;
        end
        reseat_cursors();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset coefficients: input plus a copy delayed by eight samples
        push_extremes();
        sample_queue.push_back('0);

        // ring equal to lane count, zero delay
        set_filter(16'sh8000, 16'sh7fff, 8, 0);
        push_extremes();

        // ring below minimum, delay shorter than a vector
        in_quiet  = 1'b0;
        out_quiet = 1'b0;
        set_filter(16'sh7fff, 16'sh8000, 3, 5);
        push_extremes();

        // ring above store depth, write cursor at the last entry
        set_filter(16'sh4000, 16'shc000, 8191, 4095);
        push_extremes();

        // delay longer than the ring
        set_filter(16'sh2000, 16'sh4000, 13, 20);
        push_extremes();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            r = int'($urandom_range(0, 9));
            if (r < 6) begin
                ring = int'($urandom_range(8, 40));
            end else if (r < 8) begin
                ring = int'($urandom_range(41, 4096));
            end else if (r == 8) begin
                ring = int'($urandom_range(0, 7));
            end else begin
                ring = int'($urandom_range(4097, 8191));
            end
            span = (ring < 8) ? 8 : ((ring > STORE_DEPTH) ? STORE_DEPTH : ring);
            if ($urandom_range(0, 1) == 0) begin
                dly = int'($urandom_range(0, 4095));
            end else begin
                dly = int'($urandom_range(0, (span + 10 > 4095) ? 4095 : span + 10));
            end
            set_filter(random_coef(), random_coef(), ring, dly);
            in_quiet  = (p == 1) || ($urandom_range(0, 3) == 0);
            out_quiet = (p == 1) || ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                sample_queue.push_back(random_item());
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (filtered_q.size() != 0) begin
            report_error($sformatf("%0d results never arrived", filtered_q.size()));
        end
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> vector_allpass_delay_filter.f
+incdir+sv
sv/vapd_pkg.sv
sv/vapd_ram.sv
sv/vapd_lane.sv
sv/vapd_modu.sv
sv/vector_allpass_delay_filter.sv
dv/vector_allpass_delay_filter_tb.sv
